// File: hdl/bla_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bla_pkg: shared types and constants of the battery level alarm monitor
// Sample and result word layouts, configuration register map, reset values,
// event codes and the fixed sag and charger thresholds.
// ----------------------------------------------------------------------------
package bla_pkg;

  localparam int unsigned CfgIdxWidth  = 3;
  localparam int unsigned CfgDataWidth = 16;

  typedef enum logic [CfgIdxWidth-1:0] {
    REG_WARNING_LEVEL  = 3'd0,
    REG_ERROR_LEVEL    = 3'd1,
    REG_FATAL_LEVEL    = 3'd2,
    REG_DEAD_LEVEL     = 3'd3,
    REG_CRITICAL_LIMIT = 3'd4,
    REG_SAG_LIMIT      = 3'd5,
    REG_ERROR_LIMIT    = 3'd6,
    REG_WARNING_LIMIT  = 3'd7
  } reg_idx_e;

  typedef enum logic [1:0] {
    EV_NONE    = 2'd0,
    EV_WARNING = 2'd1,
    EV_ERROR   = 2'd2,
    EV_DEAD    = 2'd3
  } event_e;

  localparam logic [15:0] WarningLevelRst  = 16'd3000;
  localparam logic [15:0] ErrorLevelRst    = 16'd2000;
  localparam logic [15:0] FatalLevelRst    = 16'd1000;
  localparam logic [15:0] DeadLevelRst     = 16'd500;
  localparam logic [7:0]  CriticalLimitRst = 8'd10;
  localparam logic [7:0]  SagLimitRst      = 8'd10;
  localparam logic [7:0]  ErrorLimitRst    = 8'd10;
  localparam logic [7:0]  WarningLimitRst  = 8'd10;

  localparam logic [7:0]         DeadStep         = 8'd3;
  localparam logic signed [15:0] SagCurrentPos    = 16'sd1000;
  localparam logic signed [15:0] SagCurrentNeg    = -16'sd1000;
  localparam logic [15:0]        SagVoltage       = 16'd10500;
  localparam logic signed [15:0] ChargerCurrent   = 16'sd1000;

  typedef struct packed {
    logic [15:0]        charge_level;
    logic [15:0]        voltage;
    logic signed [15:0] current;
  } in_word_t;

  typedef struct packed {
    logic [1:0] event_res;
    logic       loads_off;
    logic       power_off;
  } out_word_t;

  typedef struct packed {
    logic [15:0] warning_level;
    logic [15:0] error_level;
    logic [15:0] fatal_level;
    logic [15:0] dead_level;
    logic [7:0]  critical_limit;
    logic [7:0]  sag_limit;
    logic [7:0]  error_limit;
    logic [7:0]  warning_limit;
  } cfg_t;

endpackage

// File: hdl/bla_stream_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bla_stream_if: valid/ready channel
// Carries one word of the given payload type per handshake.
// ----------------------------------------------------------------------------
interface bla_stream_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// File: hdl/bla_cfg_regs.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bla_cfg_regs: configuration register file
// Write-only band levels and counter limits, loaded by index.
// ----------------------------------------------------------------------------
module bla_cfg_regs (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               we_i,
  input  logic [bla_pkg::CfgIdxWidth-1:0]    idx_i,
  input  logic [bla_pkg::CfgDataWidth-1:0]   data_i,
  output bla_pkg::cfg_t                      cfg_o
);

  bla_pkg::cfg_t cfg_q;
  bla_pkg::cfg_t cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (we_i) begin
      case (bla_pkg::reg_idx_e'(idx_i))
        bla_pkg::REG_WARNING_LEVEL:  cfg_d.warning_level  = data_i;
        bla_pkg::REG_ERROR_LEVEL:    cfg_d.error_level    = data_i;
        bla_pkg::REG_FATAL_LEVEL:    cfg_d.fatal_level    = data_i;
        bla_pkg::REG_DEAD_LEVEL:     cfg_d.dead_level     = data_i;
        bla_pkg::REG_CRITICAL_LIMIT: cfg_d.critical_limit = data_i[7:0];
        bla_pkg::REG_SAG_LIMIT:      cfg_d.sag_limit      = data_i[7:0];
        bla_pkg::REG_ERROR_LIMIT:    cfg_d.error_limit    = data_i[7:0];
        bla_pkg::REG_WARNING_LIMIT:  cfg_d.warning_limit  = data_i[7:0];
        default:                     cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.warning_level  <= bla_pkg::WarningLevelRst;
      cfg_q.error_level    <= bla_pkg::ErrorLevelRst;
      cfg_q.fatal_level    <= bla_pkg::FatalLevelRst;
      cfg_q.dead_level     <= bla_pkg::DeadLevelRst;
      cfg_q.critical_limit <= bla_pkg::CriticalLimitRst;
      cfg_q.sag_limit      <= bla_pkg::SagLimitRst;
      cfg_q.error_limit    <= bla_pkg::ErrorLimitRst;
      cfg_q.warning_limit  <= bla_pkg::WarningLimitRst;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

// File: hdl/bla_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bla_core: band sorting, alarm counters and decision
// Steps the four counters for one sample and forms the event word.
// ----------------------------------------------------------------------------
module bla_core (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                adv_i,
  input  bla_pkg::in_word_t   word_i,
  input  bla_pkg::cfg_t       cfg_i,
  output bla_pkg::out_word_t  res_o
);

  logic [7:0] crit_q, crit_d;
  logic [7:0] err_q, err_d;
  logic [7:0] warn_q, warn_d;
  logic [7:0] sag_q, sag_d;

  logic [7:0] crit_s, err_s, warn_s, sag_s;
  logic       sag_hit;

  always_comb begin
    crit_s = crit_q;
    err_s  = err_q;
    warn_s = warn_q;
    if (word_i.charge_level < cfg_i.dead_level) begin
      crit_s = crit_q + bla_pkg::DeadStep;
    end else if (word_i.charge_level < cfg_i.fatal_level) begin
      crit_s = crit_q + 8'd1;
    end else if (word_i.charge_level < cfg_i.error_level) begin
      err_s = err_q + 8'd1;
    end else if (word_i.charge_level < cfg_i.warning_level) begin
      warn_s = warn_q + 8'd1;
    end

    sag_hit = ((word_i.current > bla_pkg::SagCurrentPos) ||
               (word_i.current < bla_pkg::SagCurrentNeg)) &&
              (word_i.voltage < bla_pkg::SagVoltage);
    sag_s = sag_hit ? sag_q + 8'd1 : sag_q;

    crit_d = crit_s;
    err_d  = err_s;
    warn_d = warn_s;
    sag_d  = sag_s;
    res_o.event_res = bla_pkg::EV_NONE;
    res_o.loads_off = 1'b0;
    res_o.power_off = 1'b0;

    if ((crit_s > cfg_i.critical_limit) || (sag_s > cfg_i.sag_limit)) begin
      crit_d = 8'd0;
      sag_d  = 8'd0;
      // charger present: critical and sag counters cleared, nothing reported
      if (!(word_i.current > bla_pkg::ChargerCurrent)) begin
        res_o.event_res = bla_pkg::EV_DEAD;
        res_o.loads_off = 1'b1;
        res_o.power_off = 1'b1;
      end
    end else if (err_s > cfg_i.error_limit) begin
      err_d = 8'd0;
      res_o.event_res = bla_pkg::EV_ERROR;
      res_o.loads_off = 1'b1;
    end else if (warn_s > cfg_i.warning_limit) begin
      warn_d = 8'd0;
      res_o.event_res = bla_pkg::EV_WARNING;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      crit_q <= 8'd0;
      err_q  <= 8'd0;
      warn_q <= 8'd0;
      sag_q  <= 8'd0;
    end else if (adv_i) begin
      crit_q <= crit_d;
      err_q  <= err_d;
      warn_q <= warn_d;
      sag_q  <= sag_d;
    end
  end

endmodule

// File: hdl/battery_level_alarm_monitor_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// battery_level_alarm_monitor_top: battery charge and sag alarm monitor
//
//   channel  dir  payload                            handshake
//   in_i     in   charge_level, voltage, current     valid/ready
//   out_o    out  event_res, loads_off, power_off    valid/ready
//   cfg      in   cfg_idx_i, cfg_data_i              cfg_we_i
//
// One word per cycle sustained while out_o is ready; a result reaches out_o
// through the input register, then the result register.
// The counter update and decision are combinational between those registers.
// A stalled result holds; the input register still takes one more word.
// Reset clears counters and valids and restores the default levels.
// ----------------------------------------------------------------------------
module battery_level_alarm_monitor_top (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [bla_pkg::CfgIdxWidth-1:0]  cfg_idx_i,
  input  logic [bla_pkg::CfgDataWidth-1:0] cfg_data_i,
  bla_stream_if.sink                       in_i,
  bla_stream_if.source                     out_o
);

  bla_pkg::cfg_t      cfg;
  bla_pkg::in_word_t  in_q;
  bla_pkg::out_word_t res;
  bla_pkg::out_word_t out_q;
  logic               in_vld_q;
  logic               out_vld_q;
  logic               adv;

  bla_cfg_regs u_cfg (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .we_i   (cfg_we_i),
    .idx_i  (cfg_idx_i),
    .data_i (cfg_data_i),
    .cfg_o  (cfg)
  );

  bla_core u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .adv_i  (adv),
    .word_i (in_q),
    .cfg_i  (cfg),
    .res_o  (res)
  );

  assign adv         = in_vld_q && (!out_vld_q || out_o.ready);
  assign in_i.ready  = !in_vld_q || adv;
  assign out_o.valid = out_vld_q;
  assign out_o.data  = out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      if (in_i.ready) begin
        in_vld_q <= in_i.valid;
      end
      if (!out_vld_q || out_o.ready) begin
        out_vld_q <= in_vld_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      in_q <= in_i.data;
    end
    if (adv) begin
      out_q <= res;
    end
  end

  a_pwr_loads : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q |-> (!out_q.power_off || out_q.loads_off))
    else $error("power-off without loads off");

  a_dead_pwr : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q |-> (out_q.power_off == (out_q.event_res == bla_pkg::EV_DEAD)))
    else $error("power-off and dead event disagree");

  a_hold_in : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_vld_q && !adv) |=> (in_vld_q && $stable(in_q)))
    else $error("pending sample lost");

  a_hold_out : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_vld_q && !out_o.ready) |=> !in_i.ready || !in_vld_q || $stable(out_q))
    else $error("stalled result overwritten");

endmodule

// File: tb/tb_battery_level_alarm_monitor_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_battery_level_alarm_monitor_top: self-checking bench of the alarm monitor
// A short table of directed samples and register writes covers the band and
// decision corners. Then come random phases, each with its own register
// setting and idle pattern. Every result word is checked against a table value or
// an in-bench model of the charge bands, sag counter and alarm decision.
// ----------------------------------------------------------------------------
module tb_battery_level_alarm_monitor_top;

  localparam int CycleLimit  = 200000;
  localparam int PhaseCount  = 8;
  localparam int PhaseItems  = 192;
  localparam int HoldCycles  = 60;
  localparam int ReportLimit = 10;

  typedef enum int {ROW_SAMPLE, ROW_CFG} row_kind_e;
  typedef enum int {IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH} idle_mode_e;

  typedef struct {
    row_kind_e          kind;
    bla_pkg::reg_idx_e  idx;
    logic [15:0]        val;
    bla_pkg::in_word_t  smp;
    bit                 has_exp;
    bla_pkg::out_word_t exp;
  } row_t;

  logic                             clk_i = 1'b0;
  logic                             rst_ni;
  logic                             cfg_we_i;
  logic [bla_pkg::CfgIdxWidth-1:0]  cfg_idx_i;
  logic [bla_pkg::CfgDataWidth-1:0] cfg_data_i;

  bla_stream_if #(.payload_t(bla_pkg::in_word_t))  smp_if ();
  bla_stream_if #(.payload_t(bla_pkg::out_word_t)) alarm_if ();

  battery_level_alarm_monitor_top uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .in_i       (smp_if),
    .out_o      (alarm_if)
  );

  bla_pkg::cfg_t      lvl;
  logic [7:0]         crit_cnt, err_cnt, warn_cnt, sag_cnt;
  bla_pkg::out_word_t pending_alarms[$];
  row_t               dir_tab[$];
  int                 mismatches = 0;
  int                 cycle_cnt = 0;
  int                 send_gap_pct = 0;
  int                 recv_stall_pct = 0;
  int                 hold_reqs = 0;
  int                 hold_done = 0;
  int                 hold_left = 0;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CycleLimit) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // receiver side: random stalls plus one long hold-off
  always @(negedge clk_i) begin
    if (hold_left > 0) begin
      hold_left = hold_left - 1;
      alarm_if.ready <= 1'b0;
    end else if (hold_done != hold_reqs) begin
      hold_done = hold_done + 1;
      hold_left = HoldCycles - 1;
      alarm_if.ready <= 1'b0;
    end else begin
      alarm_if.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  function automatic bla_pkg::out_word_t step_alarm(bla_pkg::in_word_t s);
    bla_pkg::out_word_t r;
    int                 cur;
    int                 mag;
    r   = '0;
    cur = int'(s.current);
    mag = (cur < 0) ? -cur : cur;
    if (s.charge_level < lvl.dead_level) crit_cnt = crit_cnt + bla_pkg::DeadStep;
    else if (s.charge_level < lvl.fatal_level) crit_cnt = crit_cnt + 8'd1;
    else if (s.charge_level < lvl.error_level) err_cnt = err_cnt + 8'd1;
    else if (s.charge_level < lvl.warning_level) warn_cnt = warn_cnt + 8'd1;
    if (mag > bla_pkg::SagCurrentPos && s.voltage < bla_pkg::SagVoltage) begin
      sag_cnt = sag_cnt + 8'd1;
    end
    if (crit_cnt > lvl.critical_limit || sag_cnt > lvl.sag_limit) begin
      crit_cnt = '0;
      sag_cnt  = '0;
      // charger present: critical and sag counters cleared, nothing reported
      if (!(cur > bla_pkg::ChargerCurrent)) begin
        r.event_res = bla_pkg::EV_DEAD;
        r.loads_off = 1'b1;
        r.power_off = 1'b1;
      end
    end else if (err_cnt > lvl.error_limit) begin
      err_cnt     = '0;
      r.event_res = bla_pkg::EV_ERROR;
      r.loads_off = 1'b1;
    end else if (warn_cnt > lvl.warning_limit) begin
      warn_cnt    = '0;
      r.event_res = bla_pkg::EV_WARNING;
    end
    return r;
  endfunction

  function automatic row_t smp_row(logic [15:0] charge, logic [15:0] volt,
                                   logic [15:0] cur, bit has_exp, bla_pkg::event_e ev,
                                   bit loads, bit pwr);
    row_t r;
    r.kind    = ROW_SAMPLE;
    r.idx     = bla_pkg::REG_WARNING_LEVEL;
    r.val     = '0;
    r.smp     = '{charge, volt, cur};
    r.has_exp = has_exp;
    r.exp     = '{ev, loads, pwr};
    return r;
  endfunction

  function automatic row_t cfg_row(bla_pkg::reg_idx_e idx, logic [15:0] val);
    row_t r;
    r         = smp_row('0, '0, '0, 1'b0, bla_pkg::EV_NONE, 1'b0, 1'b0);
    r.kind    = ROW_CFG;
    r.idx     = idx;
    r.val     = val;
    return r;
  endfunction

  function automatic logic [15:0] pick_reg_val(int p, bla_pkg::reg_idx_e r);
    logic [15:0] rst_v;
    logic [15:0] top_v;
    bit          is_level;
    is_level = (r <= bla_pkg::REG_DEAD_LEVEL);
    top_v    = is_level ? 16'hFFFF : 16'h00FF;
    case (r)
      bla_pkg::REG_WARNING_LEVEL:  rst_v = bla_pkg::WarningLevelRst;
      bla_pkg::REG_ERROR_LEVEL:    rst_v = bla_pkg::ErrorLevelRst;
      bla_pkg::REG_FATAL_LEVEL:    rst_v = bla_pkg::FatalLevelRst;
      bla_pkg::REG_DEAD_LEVEL:     rst_v = bla_pkg::DeadLevelRst;
      bla_pkg::REG_CRITICAL_LIMIT: rst_v = {8'h00, bla_pkg::CriticalLimitRst};
      bla_pkg::REG_SAG_LIMIT:      rst_v = {8'h00, bla_pkg::SagLimitRst};
      bla_pkg::REG_ERROR_LIMIT:    rst_v = {8'h00, bla_pkg::ErrorLimitRst};
      default:                     rst_v = {8'h00, bla_pkg::WarningLimitRst};
    endcase
    case (p)
      0: return rst_v;
      1: return is_level ? top_v : 16'h0000;
      2: return is_level ? 16'h0000 : top_v;
      3: return is_level ? rst_v : top_v;
      default: begin
        case ($urandom_range(5))
          0: return 16'h0000;
          1: return top_v;
          2: return rst_v;
          default: return is_level ? 16'($urandom_range(4000)) : 16'($urandom_range(20));
        endcase
      end
    endcase
  endfunction

  function automatic bla_pkg::in_word_t rand_sample();
    bla_pkg::in_word_t s;
    logic [15:0]       lv;
    case ($urandom_range(3))
      0: lv = lvl.warning_level;
      1: lv = lvl.error_level;
      2: lv = lvl.fatal_level;
      default: lv = lvl.dead_level;
    endcase
    case ($urandom_range(9))
      0, 1: s.charge_level = 16'($urandom);
      2, 3, 4, 5: s.charge_level = 16'(lv + $urandom_range(4) - 2);
      default: s.charge_level = 16'($urandom_range(lvl.warning_level));
    endcase
    case ($urandom_range(3))
      0: s.voltage = 16'($urandom);
      1: s.voltage = 16'(bla_pkg::SagVoltage + $urandom_range(4) - 2);
      default: s.voltage = 16'($urandom_range(12000));
    endcase
    case ($urandom_range(4))
      0: s.current = 16'($urandom);
      1: s.current = 16'(1000 + int'($urandom_range(4)) - 2);
      2: s.current = 16'(-1000 + int'($urandom_range(4)) - 2);
      3: begin
        case ($urandom_range(2))
          0: s.current = 16'h8000;
          1: s.current = 16'h7FFF;
          default: s.current = 16'h0000;
        endcase
      end
      default: s.current = 16'(int'($urandom_range(3000)) - 1500);
    endcase
    return s;
  endfunction

  task automatic send_sample(bla_pkg::in_word_t w, bit has_exp, bla_pkg::out_word_t exp);
    bla_pkg::out_word_t want;
    @(negedge clk_i);
    while ($urandom_range(99) < send_gap_pct) begin
      smp_if.valid <= 1'b0;
      @(negedge clk_i);
    end
    smp_if.valid <= 1'b1;
    smp_if.data  <= w;
    do @(posedge clk_i); while (!smp_if.ready);
    want = step_alarm(w);
    pending_alarms.push_back(has_exp ? exp : want);
  endtask

  // drop valid and wait until every result is back
  task automatic settle();
    @(negedge clk_i);
    smp_if.valid <= 1'b0;
    while (pending_alarms.size() != 0) @(posedge clk_i);
    repeat (3) @(posedge clk_i);
  endtask

  task automatic write_reg(bla_pkg::reg_idx_e idx, logic [15:0] val);
    bit is_level;
    is_level = (idx <= bla_pkg::REG_DEAD_LEVEL);
    @(negedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= is_level ? val : {8'($urandom), val[7:0]};
    case (idx)
      bla_pkg::REG_WARNING_LEVEL:  lvl.warning_level  = val;
      bla_pkg::REG_ERROR_LEVEL:    lvl.error_level    = val;
      bla_pkg::REG_FATAL_LEVEL:    lvl.fatal_level    = val;
      bla_pkg::REG_DEAD_LEVEL:     lvl.dead_level     = val;
      bla_pkg::REG_CRITICAL_LIMIT: lvl.critical_limit = val[7:0];
      bla_pkg::REG_SAG_LIMIT:      lvl.sag_limit      = val[7:0];
      bla_pkg::REG_ERROR_LIMIT:    lvl.error_limit    = val[7:0];
      default:                     lvl.warning_limit  = val[7:0];
    endcase
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  always @(posedge clk_i) begin : check_alarms
    bla_pkg::out_word_t want;
    if (rst_ni && alarm_if.valid && alarm_if.ready) begin
      if (pending_alarms.size() == 0) begin
        mismatches = mismatches + 1;
        if (mismatches <= ReportLimit)
          $display("unexpected word: ev=%0d loads=%0b pwr=%0b", alarm_if.data.event_res,
                   alarm_if.data.loads_off, alarm_if.data.power_off);
      end else begin
        want = pending_alarms.pop_front();
        if (alarm_if.data.event_res !== want.event_res ||
            alarm_if.data.loads_off !== want.loads_off ||
            alarm_if.data.power_off !== want.power_off) begin
          mismatches = mismatches + 1;
          if (mismatches <= ReportLimit)
            $display({"mismatch at %0t: exp ev=%0d loads=%0b pwr=%0b, ",
                      "got ev=%0d loads=%0b pwr=%0b"},
                     $realtime, want.event_res, want.loads_off, want.power_off,
                     alarm_if.data.event_res, alarm_if.data.loads_off,
                     alarm_if.data.power_off);
        end
      end
    end
  end

  initial begin
    rst_ni         = 1'b0;
    cfg_we_i       = 1'b0;
    cfg_idx_i      = '0;
    cfg_data_i     = '0;
    smp_if.valid   = 1'b0;
    smp_if.data    = '0;
    lvl = '{bla_pkg::WarningLevelRst, bla_pkg::ErrorLevelRst, bla_pkg::FatalLevelRst,
            bla_pkg::DeadLevelRst, bla_pkg::CriticalLimitRst, bla_pkg::SagLimitRst,
            bla_pkg::ErrorLimitRst, bla_pkg::WarningLimitRst};
    crit_cnt = '0;
    err_cnt  = '0;
    warn_cnt = '0;
    sag_cnt  = '0;

    // defaults after reset
    dir_tab.push_back(smp_row(16'hFFFF, 16'hFFFF, 16'h7FFF, 1'b1,
                              bla_pkg::EV_NONE, 1'b0, 1'b0));
    dir_tab.push_back(smp_row(16'd0, 16'd0, 16'h8000, 1'b1,
                              bla_pkg::EV_NONE, 1'b0, 1'b0));
    dir_tab.push_back(smp_row(16'd999, 16'd10499, -16'sd1001, 1'b1,
                              bla_pkg::EV_NONE, 1'b0, 1'b0));
    dir_tab.push_back(smp_row(16'd1999, 16'd10500, 16'd1001, 1'b1,
                              bla_pkg::EV_NONE, 1'b0, 1'b0));
    dir_tab.push_back(smp_row(16'd2999, 16'd0, 16'd1000, 1'b1,
                              bla_pkg::EV_NONE, 1'b0, 1'b0));
    dir_tab.push_back(smp_row(16'd3000, 16'd0, -16'sd1000, 1'b1,
                              bla_pkg::EV_NONE, 1'b0, 1'b0));
    // dead battery, charger present, charger at the edge
    dir_tab.push_back(cfg_row(bla_pkg::REG_CRITICAL_LIMIT, 16'd0));
    dir_tab.push_back(smp_row(16'd500, 16'hFFFF, 16'd0, 1'b1,
                              bla_pkg::EV_DEAD, 1'b1, 1'b1));
    dir_tab.push_back(smp_row(16'd499, 16'hFFFF, 16'd1001, 1'b1,
                              bla_pkg::EV_NONE, 1'b0, 1'b0));
    dir_tab.push_back(smp_row(16'd0, 16'hFFFF, 16'd1000, 1'b1,
                              bla_pkg::EV_DEAD, 1'b1, 1'b1));
    dir_tab.push_back(cfg_row(bla_pkg::REG_CRITICAL_LIMIT, 16'd255));
    dir_tab.push_back(cfg_row(bla_pkg::REG_ERROR_LIMIT, 16'd0));
    dir_tab.push_back(smp_row(16'd1000, 16'hFFFF, 16'd0, 1'b1,
                              bla_pkg::EV_ERROR, 1'b1, 1'b0));
    dir_tab.push_back(cfg_row(bla_pkg::REG_WARNING_LIMIT, 16'd0));
    dir_tab.push_back(smp_row(16'd2000, 16'hFFFF, 16'd0, 1'b1,
                              bla_pkg::EV_WARNING, 1'b0, 1'b0));
    // sag path and its priority over error
    dir_tab.push_back(cfg_row(bla_pkg::REG_SAG_LIMIT, 16'd0));
    dir_tab.push_back(smp_row(16'hFFFF, 16'd10499, -16'sd1001, 1'b1,
                              bla_pkg::EV_DEAD, 1'b1, 1'b1));
    dir_tab.push_back(smp_row(16'hFFFF, 16'd0, 16'h7FFF, 1'b1,
                              bla_pkg::EV_NONE, 1'b0, 1'b0));
    dir_tab.push_back(smp_row(16'd1500, 16'd0, -16'sd2000, 1'b0,
                              bla_pkg::EV_NONE, 1'b0, 1'b0));
    // misordered levels
    dir_tab.push_back(cfg_row(bla_pkg::REG_SAG_LIMIT, 16'd255));
    dir_tab.push_back(cfg_row(bla_pkg::REG_DEAD_LEVEL, 16'd0));
    dir_tab.push_back(cfg_row(bla_pkg::REG_FATAL_LEVEL, 16'hFFFF));
    dir_tab.push_back(smp_row(16'hFFFE, 16'hFFFF, 16'd0, 1'b0,
                              bla_pkg::EV_NONE, 1'b0, 1'b0));
    dir_tab.push_back(smp_row(16'd0, 16'hFFFF, 16'd0, 1'b0,
                              bla_pkg::EV_NONE, 1'b0, 1'b0));

    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    foreach (dir_tab[i]) begin
      if (dir_tab[i].kind == ROW_CFG) begin
        settle();
        write_reg(dir_tab[i].idx, dir_tab[i].val);
      end else begin
        send_sample(dir_tab[i].smp, dir_tab[i].has_exp, dir_tab[i].exp);
      end
    end

    for (int p = 0; p < PhaseCount; p++) begin
      settle();
      for (int r = 0; r < 8; r++) begin
        write_reg(bla_pkg::reg_idx_e'(r), pick_reg_val(p, bla_pkg::reg_idx_e'(r)));
      end
      case (idle_mode_e'(p % 4))
        IDLE_NONE: begin
          send_gap_pct   = 0;
          recv_stall_pct = 0;
        end
        IDLE_SEND: begin
          send_gap_pct   = 58;
          recv_stall_pct = 0;
        end
        IDLE_RECV: begin
          send_gap_pct   = 0;
          recv_stall_pct = 58;
        end
        default: begin
          send_gap_pct   = 19;
          recv_stall_pct = 19;
        end
      endcase
      // long receiver hold-off while samples keep coming
      if (p == 4) hold_reqs = hold_reqs + 1;
      for (int n = 0; n < PhaseItems; n++) send_sample(rand_sample(), 1'b0, '0);
    end

    @(negedge clk_i);
    smp_if.valid <= 1'b0;
    while (pending_alarms.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
